@@ src/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Rolling block checksum package
// Shared widths, register indexes and defaults for the checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

   localparam int MAX_BLOCK_SHIFT_DEF = 12;
   localparam int MIN_BLOCK_SHIFT     = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam int SUM_W      = 16;
   localparam int BYTE_W     = 8;

   localparam logic [CSR_DATA_W-1:0] BLOCK_SHIFT_RST = 4'd10;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SHIFT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_BLOCK_MODE = 1'd1;

endpackage

`default_nettype wire

@@ src/rolling_block_checksum.sv @@
// ----------------------------------------------------------------------------
// Rolling block checksum
// Input stage, then response register. One request per cycle unless the
// response stalls; one history write and two reads per cycle. Reset clears
// pipe, sums, fill count; history is not cleared, unfilled positions read as 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_block_checksum
   import rbc_pkg::*;
#(
   parameter int MAX_BLOCK_SHIFT = MAX_BLOCK_SHIFT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_restart,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SUM_W-1:0]           rsp_sum_a_first,
   output logic [SUM_W-1:0]           rsp_sum_b_first,
   output logic [SUM_W-1:0]           rsp_sum_a_second,
   output logic [SUM_W-1:0]           rsp_sum_b_second,
   output logic                       rsp_window_full,

   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = MAX_BLOCK_SHIFT + 1;
   localparam int DEPTH = 1 << AW;
   localparam int FCW   = MAX_BLOCK_SHIFT + 2;
   localparam int SW    = $clog2(MAX_BLOCK_SHIFT + 1);

   // configuration
   logic [CSR_DATA_W-1:0] block_shift_ff;
   logic                  two_block_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff    <= BLOCK_SHIFT_RST;
         two_block_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_BLOCK_SHIFT:    block_shift_ff    <= csr_wdata;
            REG_TWO_BLOCK_MODE: two_block_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturate block shift
   logic [4:0]    bs_ext;
   logic [SW-1:0] shift;
   logic [AW-1:0] blk;
   logic [FCW-1:0] blk_x2;

   always_comb begin
      bs_ext = {1'b0, block_shift_ff};
      if (bs_ext < 5'(MIN_BLOCK_SHIFT)) begin
         shift = SW'(MIN_BLOCK_SHIFT);
      end else if (bs_ext > 5'(MAX_BLOCK_SHIFT)) begin
         shift = SW'(MAX_BLOCK_SHIFT);
      end else begin
         shift = SW'(bs_ext);
      end
      blk    = AW'(1) << shift;
      blk_x2 = {blk, 1'b0};
   end

   // handshake
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic s1_valid_ff;
   logic s1_valid_in;
   logic out_open;
   logic s1_adv;
   logic req_acc;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_open;
   assign req_ready = !s1_valid_ff || out_open;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // fill count and write pointer
   logic [FCW-1:0] fill_count_ff;
   logic [FCW-1:0] fill_count_in;
   logic [FCW-1:0] fill_cur;
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  mid_addr;
   logic [AW-1:0]  old_addr;
   logic           mid_ok;
   logic           old_ok;
   logic           full_now;

   always_comb begin
      fill_cur = req_restart ? '0 : fill_count_ff;
      mid_ok   = fill_cur >= {1'b0, blk};
      old_ok   = fill_cur >= blk_x2;
      if (fill_cur == FCW'(DEPTH)) begin
         fill_count_in = fill_cur;
      end else begin
         fill_count_in = fill_cur + FCW'(1);
      end
      full_now  = two_block_mode_ff ? (fill_count_in >= blk_x2)
                                    : (fill_count_in >= {1'b0, blk});
      wr_ptr_in = wr_ptr_ff + AW'(1);
      mid_addr  = wr_ptr_ff - blk;
      old_addr  = wr_ptr_ff - blk_x2[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         wr_ptr_ff     <= '0;
      end else if (req_acc) begin
         fill_count_ff <= fill_count_in;
         wr_ptr_ff     <= wr_ptr_in;
      end
   end

   // byte history
   logic [BYTE_W-1:0] hist_mem [DEPTH];
   logic [BYTE_W-1:0] mid_rd_ff;
   logic [BYTE_W-1:0] old_rd_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hist_mem[wr_ptr_ff] <= req_data_byte;
         mid_rd_ff           <= hist_mem[mid_addr];
         old_rd_ff           <= hist_mem[old_addr];
      end
   end

   // input stage
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_restart_ff;
   logic              s1_mid_ok_ff;
   logic              s1_old_ok_ff;
   logic [SW-1:0]     s1_shift_ff;
   logic              s1_mode_ff;
   logic              s1_full_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_byte_ff    <= req_data_byte;
         s1_restart_ff <= req_restart;
         s1_mid_ok_ff  <= mid_ok;
         s1_old_ok_ff  <= old_ok;
         s1_shift_ff   <= shift;
         s1_mode_ff    <= two_block_mode_ff;
         s1_full_ff    <= full_now;
      end
   end

   // roll both windows
   logic [SUM_W-1:0]  first_a_ff, first_b_ff, second_a_ff, second_b_ff;
   logic [SUM_W-1:0]  first_a_in, first_b_in, second_a_in, second_b_in;
   logic [SUM_W-1:0]  base_fa, base_fb, base_sa, base_sb;
   logic [BYTE_W-1:0] mid_byte;
   logic [BYTE_W-1:0] old_byte;

   always_comb begin
      base_fa     = s1_restart_ff ? '0 : first_a_ff;
      base_fb     = s1_restart_ff ? '0 : first_b_ff;
      base_sa     = s1_restart_ff ? '0 : second_a_ff;
      base_sb     = s1_restart_ff ? '0 : second_b_ff;
      mid_byte    = s1_mid_ok_ff ? mid_rd_ff : '0;
      old_byte    = s1_old_ok_ff ? old_rd_ff : '0;
      second_a_in = base_sa + SUM_W'(s1_byte_ff) - SUM_W'(mid_byte);
      second_b_in = base_sb + second_a_in - (SUM_W'(mid_byte) << s1_shift_ff);
      first_a_in  = base_fa + SUM_W'(mid_byte) - SUM_W'(old_byte);
      first_b_in  = base_fb + first_a_in - (SUM_W'(old_byte) << s1_shift_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_a_ff  <= '0;
         first_b_ff  <= '0;
         second_a_ff <= '0;
         second_b_ff <= '0;
      end else if (s1_adv) begin
         first_a_ff  <= first_a_in;
         first_b_ff  <= first_b_in;
         second_a_ff <= second_a_in;
         second_b_ff <= second_b_in;
      end
   end

   // response register
   logic [SUM_W-1:0] rsp_a_first_ff, rsp_b_first_ff, rsp_a_second_ff, rsp_b_second_ff;
   logic             rsp_full_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_mode_ff) begin
            rsp_a_first_ff  <= first_a_in;
            rsp_b_first_ff  <= first_b_in;
            rsp_a_second_ff <= second_a_in;
            rsp_b_second_ff <= second_b_in;
         end else begin
            rsp_a_first_ff  <= second_a_in;
            rsp_b_first_ff  <= second_b_in;
            rsp_a_second_ff <= '0;
            rsp_b_second_ff <= '0;
         end
         rsp_full_ff <= s1_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_sum_a_first  = rsp_a_first_ff;
   assign rsp_sum_b_first  = rsp_b_first_ff;
   assign rsp_sum_a_second = rsp_a_second_ff;
   assign rsp_sum_b_second = rsp_b_second_ff;
   assign rsp_window_full  = rsp_full_ff;

endmodule

`default_nettype wire

@@ src/rbc_checker.sv @@
// ----------------------------------------------------------------------------
// Rolling block checksum checker
// Port-level assertions on the checksum block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_checker
   import rbc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [SUM_W-1:0]      rsp_sum_a_first,
   input wire logic [SUM_W-1:0]      rsp_sum_b_first,
   input wire logic [SUM_W-1:0]      rsp_sum_a_second,
   input wire logic [SUM_W-1:0]      rsp_sum_b_second,
   input wire logic                  rsp_window_full,
   input wire logic                  csr_write_en,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // track mode
   logic mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write_en && csr_index == REG_TWO_BLOCK_MODE) begin
         mode_ff <= csr_wdata[0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_a_first)
         && $stable(rsp_sum_b_first) && $stable(rsp_sum_a_second)
         && $stable(rsp_sum_b_second) && $stable(rsp_window_full))
      else $error("response dropped or changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mode_ff |-> rsp_sum_a_second == '0 && rsp_sum_b_second == '0)
      else $error("second window reported in single-block mode");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rolling_block_checksum rbc_checker u_rbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sum_a_first  (rsp_sum_a_first),
   .rsp_sum_b_first  (rsp_sum_b_first),
   .rsp_sum_a_second (rsp_sum_a_second),
   .rsp_sum_b_second (rsp_sum_b_second),
   .rsp_window_full  (rsp_window_full),
   .csr_write_en     (csr_write_en),
   .csr_index        (csr_index),
   .csr_wdata        (csr_wdata)
);

`default_nettype wire
